/* rtl/mp2q_pkg.sv */
// shared types, widths and constants of the 2-d max pooling unit
// no dependencies; every other file of the unit but mp2q_if uses it
`default_nettype none

package mp2q_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int HEIGHT_W   = 10;
  localparam int WIDTH_W    = 7;
  localparam int CHAN_W     = 7;
  localparam int KERN_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int LIMIT_W    = 11;

  // reciprocal multiply: q = (n * ceil(2^14 / s)) >> 14 is exact for n < 1024, s < 16
  localparam int RECIP_SHIFT = 14;
  localparam int RECIP_W     = 15;
  localparam int PROD_R_W    = HEIGHT_W + RECIP_W;
  localparam int PROD_C_W    = WIDTH_W + RECIP_W;

  localparam int DEF_MAX_COLUMNS  = 64;
  localparam int DEF_MAX_CHANNELS = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAP_HEIGHT    = 3'd0,
    REG_MAP_WIDTH     = 3'd1,
    REG_CHANNEL_COUNT = 3'd2,
    REG_KERNEL_ROWS   = 3'd3,
    REG_KERNEL_COLS   = 3'd4,
    REG_STRIDE_ROWS   = 3'd5,
    REG_STRIDE_COLS   = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       map_start;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] pooled;
    logic                       map_done;
  } out_word_t;

  // effective shape after clamping, plus the derived output size
  typedef struct packed {
    logic [HEIGHT_W-1:0] h;
    logic [WIDTH_W-1:0]  w;
    logic [CHAN_W-1:0]   chn;
    logic [KERN_W-1:0]   sr;
    logic [KERN_W-1:0]   sc;
    logic [KERN_W-1:0]   kr;
    logic [KERN_W-1:0]   kc;
    logic [RECIP_W-1:0]  recip_r;
    logic [RECIP_W-1:0]  recip_c;
    logic [HEIGHT_W-1:0] out_h;
    logic [WIDTH_W-1:0]  out_w;
  } cfg_t;

  // one word on its way to the max memory
  typedef struct packed {
    logic                       valid;
    logic                       hit;
    logic                       first;
    logic                       last;
    logic                       done;
    logic signed [SAMPLE_W-1:0] sample;
  } pos_t;

  function automatic logic [RECIP_W-1:0] recip(input logic [KERN_W-1:0] s);
    logic [RECIP_W-1:0] r;
    unique case (s)
      4'd2:    r = 15'd8192;
      4'd3:    r = 15'd5462;
      4'd4:    r = 15'd4096;
      4'd5:    r = 15'd3277;
      4'd6:    r = 15'd2731;
      4'd7:    r = 15'd2341;
      4'd8:    r = 15'd2048;
      4'd9:    r = 15'd1821;
      4'd10:   r = 15'd1639;
      4'd11:   r = 15'd1490;
      4'd12:   r = 15'd1366;
      4'd13:   r = 15'd1261;
      4'd14:   r = 15'd1171;
      4'd15:   r = 15'd1093;
      default: r = 15'd16384;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/mp2q_if.sv */
// valid/ready stream channel carrying one word of a given type
// word types come from mp2q_pkg
`default_nettype none

interface mp2q_if #(
  parameter type word_t = logic
) ();
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/mp2q_cfg.sv */
// configuration registers, clamping to legal shapes and derived output size
// depends on mp2q_pkg
`default_nettype none

module mp2q_cfg #(
  parameter int MAX_COLUMNS  = mp2q_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_CHANNELS = mp2q_pkg::DEF_MAX_CHANNELS
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [mp2q_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [mp2q_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output mp2q_pkg::cfg_t                         cfg_o
);

  logic [mp2q_pkg::HEIGHT_W-1:0] height_q;
  logic [mp2q_pkg::WIDTH_W-1:0]  width_q;
  logic [mp2q_pkg::CHAN_W-1:0]   chans_q;
  logic [mp2q_pkg::KERN_W-1:0]   krows_q, kcols_q, srows_q, scols_q;
  logic [mp2q_pkg::HEIGHT_W-1:0] out_h_q, out_h_d;
  logic [mp2q_pkg::WIDTH_W-1:0]  out_w_q, out_w_d;

  logic [mp2q_pkg::WIDTH_W-1:0]  w_raw;
  logic [mp2q_pkg::CHAN_W-1:0]   c_raw;
  logic [mp2q_pkg::KERN_W-1:0]   kr_raw, kc_raw;
  logic [mp2q_pkg::PROD_R_W-1:0] oh_prod;
  logic [mp2q_pkg::PROD_C_W-1:0] ow_prod;
  mp2q_pkg::cfg_t                cfg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= 10'd1;
      width_q  <= 7'd1;
      chans_q  <= 7'd1;
      krows_q  <= 4'd2;
      kcols_q  <= 4'd2;
      srows_q  <= 4'd2;
      scols_q  <= 4'd2;
      out_h_q  <= '0;
      out_w_q  <= '0;
    end else begin
      out_h_q <= out_h_d;
      out_w_q <= out_w_d;
      if (cfg_we_i) begin
        unique case (mp2q_pkg::cfg_reg_e'(cfg_idx_i))
          mp2q_pkg::REG_MAP_HEIGHT:    height_q <= cfg_data_i;
          mp2q_pkg::REG_MAP_WIDTH:     width_q  <= cfg_data_i[mp2q_pkg::WIDTH_W-1:0];
          mp2q_pkg::REG_CHANNEL_COUNT: chans_q  <= cfg_data_i[mp2q_pkg::CHAN_W-1:0];
          mp2q_pkg::REG_KERNEL_ROWS:   krows_q  <= cfg_data_i[mp2q_pkg::KERN_W-1:0];
          mp2q_pkg::REG_KERNEL_COLS:   kcols_q  <= cfg_data_i[mp2q_pkg::KERN_W-1:0];
          mp2q_pkg::REG_STRIDE_ROWS:   srows_q  <= cfg_data_i[mp2q_pkg::KERN_W-1:0];
          mp2q_pkg::REG_STRIDE_COLS:   scols_q  <= cfg_data_i[mp2q_pkg::KERN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    cfg = '0;
    cfg.h  = (height_q == '0) ? 10'd1 : height_q;
    w_raw  = (width_q == '0) ? 7'd1 : width_q;
    c_raw  = (chans_q == '0) ? 7'd1 : chans_q;
    cfg.w  = (mp2q_pkg::LIMIT_W'(w_raw) > mp2q_pkg::LIMIT_W'(MAX_COLUMNS))
             ? mp2q_pkg::WIDTH_W'(MAX_COLUMNS) : w_raw;
    cfg.chn = (mp2q_pkg::LIMIT_W'(c_raw) > mp2q_pkg::LIMIT_W'(MAX_CHANNELS))
              ? mp2q_pkg::CHAN_W'(MAX_CHANNELS) : c_raw;
    cfg.sr = (srows_q == '0) ? 4'd1 : srows_q;
    cfg.sc = (scols_q == '0) ? 4'd1 : scols_q;
    kr_raw = (krows_q == '0) ? 4'd1 : krows_q;
    kc_raw = (kcols_q == '0) ? 4'd1 : kcols_q;
    cfg.kr = (kr_raw > cfg.sr) ? cfg.sr : kr_raw;
    cfg.kc = (kc_raw > cfg.sc) ? cfg.sc : kc_raw;
    cfg.recip_r = mp2q_pkg::recip(cfg.sr);
    cfg.recip_c = mp2q_pkg::recip(cfg.sc);
    // output size is registered from the clamped shape, so after a write it settles later than the other fields
    oh_prod = mp2q_pkg::PROD_R_W'(cfg.h) * mp2q_pkg::PROD_R_W'(cfg.recip_r);
    ow_prod = mp2q_pkg::PROD_C_W'(cfg.w) * mp2q_pkg::PROD_C_W'(cfg.recip_c);
    out_h_d = mp2q_pkg::HEIGHT_W'(oh_prod >> mp2q_pkg::RECIP_SHIFT);
    out_w_d = mp2q_pkg::WIDTH_W'(ow_prod >> mp2q_pkg::RECIP_SHIFT);
    cfg.out_h = out_h_q;
    cfg.out_w = out_w_q;
  end

  assign cfg_o = cfg;

endmodule

`default_nettype wire

/* rtl/mp2q_addr.sv */
// position counters and window decode: turns each accepted sample into
// a memory address and first/last/done flags; depends on mp2q_pkg
`default_nettype none

module mp2q_addr #(
  parameter int MAX_CHANNELS = mp2q_pkg::DEF_MAX_CHANNELS,
  parameter int AW           = 12
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire mp2q_pkg::cfg_t     cfg_i,
  input  wire logic               en_i,
  input  wire logic               acc_i,
  input  wire mp2q_pkg::in_word_t word_i,
  output mp2q_pkg::pos_t          pos_o,
  output logic [AW-1:0]           idx_o
);

  logic [mp2q_pkg::HEIGHT_W-1:0] row_q;
  logic [mp2q_pkg::WIDTH_W-1:0]  col_q;
  logic [mp2q_pkg::CHAN_W-1:0]   chan_q;

  logic [mp2q_pkg::HEIGHT_W-1:0] p_row;
  logic [mp2q_pkg::WIDTH_W-1:0]  p_col;
  logic [mp2q_pkg::CHAN_W-1:0]   p_chan;
  logic [mp2q_pkg::HEIGHT_W:0]   row_inc;
  logic [mp2q_pkg::WIDTH_W:0]    col_inc;
  logic [mp2q_pkg::CHAN_W:0]     chan_inc;
  logic                          wrap_chan, wrap_col, wrap_row;

  logic                          b_valid_q;
  logic [mp2q_pkg::HEIGHT_W-1:0] b_row_q;
  logic [mp2q_pkg::WIDTH_W-1:0]  b_col_q;
  logic [mp2q_pkg::CHAN_W-1:0]   b_chan_q;
  logic                          b_inshape_q;
  logic signed [mp2q_pkg::SAMPLE_W-1:0] b_sample_q;
  logic [mp2q_pkg::PROD_R_W-1:0] b_prod_r_q;
  logic [mp2q_pkg::PROD_C_W-1:0] b_prod_c_q;

  logic [mp2q_pkg::HEIGHT_W-1:0] oh, dr;
  logic [mp2q_pkg::WIDTH_W-1:0]  ow, dc;
  logic                          win;

  // map_start restarts the position before this sample is placed
  always_comb begin
    p_row     = word_i.map_start ? '0 : row_q;
    p_col     = word_i.map_start ? '0 : col_q;
    p_chan    = word_i.map_start ? '0 : chan_q;
    chan_inc  = {1'b0, p_chan} + 8'd1;
    col_inc   = {1'b0, p_col} + 8'd1;
    row_inc   = {1'b0, p_row} + 11'd1;
    wrap_chan = chan_inc >= {1'b0, cfg_i.chn};
    wrap_col  = col_inc >= {1'b0, cfg_i.w};
    wrap_row  = row_inc >= {1'b0, cfg_i.h};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q     <= '0;
      col_q     <= '0;
      chan_q    <= '0;
      b_valid_q <= 1'b0;
    end else begin
      if (en_i) begin
        b_valid_q <= acc_i;
      end
      if (acc_i) begin
        chan_q <= wrap_chan ? '0 : chan_inc[mp2q_pkg::CHAN_W-1:0];
        col_q  <= p_col;
        row_q  <= p_row;
        if (wrap_chan) begin
          col_q <= wrap_col ? '0 : col_inc[mp2q_pkg::WIDTH_W-1:0];
          if (wrap_col) begin
            row_q <= wrap_row ? '0 : row_inc[mp2q_pkg::HEIGHT_W-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_row_q     <= p_row;
      b_col_q     <= p_col;
      b_chan_q    <= p_chan;
      b_sample_q  <= word_i.sample;
      b_inshape_q <= (p_row < cfg_i.h) && (p_col < cfg_i.w) && (p_chan < cfg_i.chn);
      b_prod_r_q  <= mp2q_pkg::PROD_R_W'(p_row) * mp2q_pkg::PROD_R_W'(cfg_i.recip_r);
      b_prod_c_q  <= mp2q_pkg::PROD_C_W'(p_col) * mp2q_pkg::PROD_C_W'(cfg_i.recip_c);
    end
  end

  // window index and offset inside the window
  always_comb begin
    oh  = mp2q_pkg::HEIGHT_W'(b_prod_r_q >> mp2q_pkg::RECIP_SHIFT);
    ow  = mp2q_pkg::WIDTH_W'(b_prod_c_q >> mp2q_pkg::RECIP_SHIFT);
    dr  = b_row_q - (oh * mp2q_pkg::HEIGHT_W'(cfg_i.sr));
    dc  = b_col_q - (ow * mp2q_pkg::WIDTH_W'(cfg_i.sc));
    win = b_inshape_q && (oh < cfg_i.out_h) && (ow < cfg_i.out_w) &&
          (dr < mp2q_pkg::HEIGHT_W'(cfg_i.kr)) && (dc < mp2q_pkg::WIDTH_W'(cfg_i.kc));

    pos_o.valid  = b_valid_q;
    pos_o.hit    = win;
    pos_o.first  = (dr == '0) && (dc == '0);
    pos_o.last   = (dr == mp2q_pkg::HEIGHT_W'(cfg_i.kr) - 10'd1) &&
                   (dc == mp2q_pkg::WIDTH_W'(cfg_i.kc) - 7'd1);
    pos_o.done   = (oh == cfg_i.out_h - 10'd1) && (ow == cfg_i.out_w - 7'd1) &&
                   (b_chan_q == cfg_i.chn - 7'd1);
    pos_o.sample = b_sample_q;
    idx_o        = AW'(32'(ow) * MAX_CHANNELS + 32'(b_chan_q));
  end

endmodule

`default_nettype wire

/* rtl/mp2q_ram.sv */
// simple dual-port memory of running maxima: one write and one
// registered read per cycle; depends on mp2q_pkg for the word width
`default_nettype none

module mp2q_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic                                clk_i,
  input  wire logic                                we_i,
  input  wire logic [AW-1:0]                       waddr_i,
  input  wire logic signed [mp2q_pkg::SAMPLE_W-1:0] wdata_i,
  input  wire logic                                re_i,
  input  wire logic [AW-1:0]                       raddr_i,
  output logic signed [mp2q_pkg::SAMPLE_W-1:0]     rdata_o
);

  logic signed [mp2q_pkg::SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/max_pool_2d_q15_unit.sv */
// 2-d max pooling of a q15 feature map streamed in channel-last raster order.
// One word is taken per cycle except while a finished word waits at the output,
// the only time input ready drops; a pooled word passes the position,
// read-modify-write and output registers after the sample that closes its
// window. The rate is set by the running-max memory, which sees one read and
// one read-modify-write per cycle; a read of an entry written in the same cycle
// is forwarded. The memory holds MAX_COLUMNS * MAX_CHANNELS maxima and needs no
// clearing after reset: the first sample of each window overwrites its entry.
`default_nettype none

module max_pool_2d_q15_unit #(
  parameter int MAX_COLUMNS  = mp2q_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_CHANNELS = mp2q_pkg::DEF_MAX_CHANNELS
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  mp2q_if.sink                                  in_i,
  mp2q_if.source                                out_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [mp2q_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [mp2q_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int DEPTH = MAX_COLUMNS * MAX_CHANNELS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  mp2q_pkg::cfg_t     cfg;
  mp2q_pkg::pos_t     pos;
  mp2q_pkg::in_word_t in_word;
  logic [AW-1:0]      idx;
  logic               en, acc;

  logic               c_valid_q;
  mp2q_pkg::pos_t     c_pos_q;
  logic [AW-1:0]      c_idx_q;
  logic               fwd_hit_q, fwd_hit_d;
  logic signed [mp2q_pkg::SAMPLE_W-1:0] fwd_data_q;
  logic signed [mp2q_pkg::SAMPLE_W-1:0] rd_data, cur, new_max;
  logic               mem_we;

  logic               out_valid_q;
  mp2q_pkg::out_word_t out_word_q;

  // whole pipeline moves together; it holds only while a result waits
  assign en        = !out_valid_q || out_o.ready;
  assign acc       = in_i.valid && en;
  assign in_i.ready = en;
  assign in_word   = in_i.data;

  mp2q_cfg #(
    .MAX_COLUMNS  (MAX_COLUMNS),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  mp2q_addr #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .AW           (AW)
  ) u_addr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .en_i   (en),
    .acc_i  (acc),
    .word_i (in_word),
    .pos_o  (pos),
    .idx_o  (idx)
  );

  mp2q_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (c_idx_q),
    .wdata_i (new_max),
    .re_i    (en),
    .raddr_i (idx),
    .rdata_o (rd_data)
  );

  // read-modify-write of the running maximum
  always_comb begin
    cur       = fwd_hit_q ? fwd_data_q : rd_data;
    new_max   = (c_pos_q.first || (c_pos_q.sample > cur)) ? c_pos_q.sample : cur;
    mem_we    = en && c_valid_q && c_pos_q.hit;
    // the memory returns the old value when the entry is written in the same cycle
    fwd_hit_d = mem_we && pos.valid && pos.hit && (idx == c_idx_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q   <= 1'b0;
      fwd_hit_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      c_valid_q   <= pos.valid;
      fwd_hit_q   <= fwd_hit_d;
      out_valid_q <= c_valid_q && c_pos_q.hit && c_pos_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_pos_q             <= pos;
      c_idx_q             <= idx;
      fwd_data_q          <= new_max;
      out_word_q.pooled   <= new_max;
      out_word_q.map_done <= c_pos_q.done;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_word_q;

endmodule

`default_nettype wire

/* rtl/mp2q_checker.sv */
// port-level checks of the max pooling unit, bound to its top level
// depends on mp2q_pkg and max_pool_2d_q15_unit
`default_nettype none

module mp2q_checker (
  input wire logic                                 clk_i,
  input wire logic                                 rst_ni,
  input wire logic                                 in_ready_i,
  input wire logic                                 out_valid_i,
  input wire logic                                 out_ready_i,
  input wire logic signed [mp2q_pkg::SAMPLE_W-1:0] out_pooled_i,
  input wire logic                                 out_done_i
);

  // a waiting word holds still until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_pooled_i) && $stable(out_done_i))
    else $error("output word changed while stalled");

  // input is refused only while a finished word waits
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == (!out_valid_i || out_ready_i))
    else $error("input ready does not follow output state");

  // no word is shown during reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("output valid during reset");

endmodule

bind max_pool_2d_q15_unit mp2q_checker u_mp2q_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_pooled_i (out_o.data.pooled),
  .out_done_i   (out_o.data.map_done)
);

`default_nettype wire

/* sim/tb_max_pool_2d_q15_unit.sv */
// self-checking testbench of the 2-d q15 max pooling unit: valid/ready stream in and out,
// with its own pooling predictor and random stalls on both sides
// depends on mp2q_pkg, mp2q_if and max_pool_2d_q15_unit from rtl
`timescale 1ns / 100ps

module tb_max_pool_2d_q15_unit;

  localparam int unsigned MAX_COLS  = mp2q_pkg::DEF_MAX_COLUMNS;
  localparam int unsigned MAX_CHANS = mp2q_pkg::DEF_MAX_CHANNELS;
  localparam int unsigned RANDOM_WORDS = 300;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [mp2q_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [mp2q_pkg::CFG_DATA_W-1:0] cfg_data_i;

  mp2q_if #(.word_t(mp2q_pkg::in_word_t))  feed_ch ();
  mp2q_if #(.word_t(mp2q_pkg::out_word_t)) pool_ch ();

  max_pool_2d_q15_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (feed_ch),
    .out_o      (pool_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shape registers as the unit holds them
  logic [mp2q_pkg::HEIGHT_W-1:0] cfg_h;
  logic [mp2q_pkg::WIDTH_W-1:0]  cfg_w;
  logic [mp2q_pkg::CHAN_W-1:0]   cfg_c;
  logic [mp2q_pkg::KERN_W-1:0]   cfg_kr, cfg_kc, cfg_sr, cfg_sc;

  // pooling state: one running maximum per output column and channel
  logic signed [mp2q_pkg::SAMPLE_W-1:0] max_mem [0:MAX_COLS*MAX_CHANS-1];
  int unsigned pos_row, pos_col, pos_chan;

  mp2q_pkg::in_word_t  feed_q [$];
  mp2q_pkg::out_word_t pooled_q [$];
  int unsigned pushed, taken, checked, fail_count, shape_count;
  int unsigned feed_wait, drain_wait;
  bit          src_calm, sink_calm;

  function automatic void shape_now(output int unsigned h, w, chn, sr, sc, kr, kc);
    h   = (cfg_h == 0) ? 1 : cfg_h;
    w   = (cfg_w == 0) ? 1 : ((cfg_w > MAX_COLS) ? MAX_COLS : cfg_w);
    chn = (cfg_c == 0) ? 1 : ((cfg_c > MAX_CHANS) ? MAX_CHANS : cfg_c);
    sr  = (cfg_sr == 0) ? 1 : cfg_sr;
    sc  = (cfg_sc == 0) ? 1 : cfg_sc;
    kr  = (cfg_kr == 0) ? 1 : cfg_kr;
    kc  = (cfg_kc == 0) ? 1 : cfg_kc;
    if (kr > sr) kr = sr;
    if (kc > sc) kc = sc;
  endfunction

  // fold one accepted sample into the running maxima, queue the pooled word it closes
  function automatic void pool_step(mp2q_pkg::in_word_t word);
    int unsigned h, w, chn, sr, sc, kr, kc, oh, ow, dr, dc, slot;
    mp2q_pkg::out_word_t res;
    shape_now(h, w, chn, sr, sc, kr, kc);
    if (word.map_start) begin
      pos_row  = 0;
      pos_col  = 0;
      pos_chan = 0;
    end
    if (pos_row < h && pos_col < w && pos_chan < chn) begin
      oh = pos_row / sr;
      dr = pos_row % sr;
      ow = pos_col / sc;
      dc = pos_col % sc;
      if (oh < h / sr && ow < w / sc && dr < kr && dc < kc) begin
        slot = ow * MAX_CHANS + pos_chan;
        if ((dr == 0 && dc == 0) || word.sample > max_mem[slot])
          max_mem[slot] = word.sample;
        if (dr == kr - 1 && dc == kc - 1) begin
          res.pooled   = max_mem[slot];
          res.map_done = (oh == h / sr - 1 && ow == w / sc - 1 && pos_chan == chn - 1);
          pooled_q.push_back(res);
        end
      end
    end
    // position wraps channel, then column, then row
    pos_chan++;
    if (pos_chan >= chn) begin
      pos_chan = 0;
      pos_col++;
      if (pos_col >= w) begin
        pos_col = 0;
        pos_row++;
        if (pos_row >= h) pos_row = 0;
      end
    end
  endfunction

  function automatic logic signed [mp2q_pkg::SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return mp2q_pkg::SAMPLE_W'($urandom_range(0, 7)) - 16'sd4;
      default: return mp2q_pkg::SAMPLE_W'($urandom());
    endcase
  endfunction

  function automatic void push_word(logic signed [mp2q_pkg::SAMPLE_W-1:0] s, logic start);
    mp2q_pkg::in_word_t word;
    word.sample    = s;
    word.map_start = start;
    feed_q.push_back(word);
    pushed++;
  endfunction

  // source side: holds valid until taken, then waits a drawn gap before the next word
  always @(posedge clk_i) begin : feed_drive
    logic               nv;
    mp2q_pkg::in_word_t nd;
    if (rst_ni) begin
      nv = feed_ch.valid;
      nd = feed_ch.data;
      if (feed_ch.valid && feed_ch.ready) begin
        pool_step(feed_ch.data);
        taken++;
        nv = 1'b0;
      end
      if (!nv) begin
        if (feed_wait != 0) begin
          feed_wait--;
        end else if (feed_q.size() != 0) begin
          nd        = feed_q.pop_front();
          nv        = 1'b1;
          feed_wait = src_calm ? 0 : $urandom_range(0, 14);
        end
      end
      feed_ch.valid <= nv;
      feed_ch.data  <= nd;
    end
  end

  // sink side: checks every pooled word, then stalls for a drawn number of cycles
  always @(posedge clk_i) begin : pooled_check
    logic                nr;
    mp2q_pkg::out_word_t want;
    if (rst_ni) begin
      nr = pool_ch.ready;
      if (pool_ch.valid && pool_ch.ready) begin
        checked++;
        if (pooled_q.size() == 0) begin
          $display("%0t: unexpected pooled word %0d done %0b", $time,
                   pool_ch.data.pooled, pool_ch.data.map_done);
          fail_count++;
        end else begin
          want = pooled_q.pop_front();
          if (pool_ch.data.pooled !== want.pooled) begin
            $display("%0t: pooled expected %0d, got %0d", $time, want.pooled,
                     pool_ch.data.pooled);
            fail_count++;
          end
          if (pool_ch.data.map_done !== want.map_done) begin
            $display("%0t: map_done expected %0b, got %0b", $time, want.map_done,
                     pool_ch.data.map_done);
            fail_count++;
          end
        end
        drain_wait = sink_calm ? 0 : $urandom_range(0, 14);
        if (drain_wait != 0) nr = 1'b0;
      end else if (!nr) begin
        if (drain_wait > 1) begin
          drain_wait--;
        end else begin
          drain_wait = 0;
          nr = 1'b1;
        end
      end
      pool_ch.ready <= nr;
    end
  end

  // everything taken and delivered, plus a wait for words that close no window
  task automatic settle();
    while (taken != pushed || pooled_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic put_reg(mp2q_pkg::cfg_reg_e idx, int unsigned val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= mp2q_pkg::CFG_DATA_W'(val);
    case (idx)
      mp2q_pkg::REG_MAP_HEIGHT:    cfg_h  = mp2q_pkg::HEIGHT_W'(val);
      mp2q_pkg::REG_MAP_WIDTH:     cfg_w  = mp2q_pkg::WIDTH_W'(val);
      mp2q_pkg::REG_CHANNEL_COUNT: cfg_c  = mp2q_pkg::CHAN_W'(val);
      mp2q_pkg::REG_KERNEL_ROWS:   cfg_kr = mp2q_pkg::KERN_W'(val);
      mp2q_pkg::REG_KERNEL_COLS:   cfg_kc = mp2q_pkg::KERN_W'(val);
      mp2q_pkg::REG_STRIDE_ROWS:   cfg_sr = mp2q_pkg::KERN_W'(val);
      mp2q_pkg::REG_STRIDE_COLS:   cfg_sc = mp2q_pkg::KERN_W'(val);
      default: ;
    endcase
  endtask

  task automatic set_shape(int unsigned h, w, chn, kr, kc, sr, sc);
    settle();
    put_reg(mp2q_pkg::REG_MAP_HEIGHT, h);
    put_reg(mp2q_pkg::REG_MAP_WIDTH, w);
    put_reg(mp2q_pkg::REG_CHANNEL_COUNT, chn);
    put_reg(mp2q_pkg::REG_KERNEL_ROWS, kr);
    put_reg(mp2q_pkg::REG_KERNEL_COLS, kc);
    put_reg(mp2q_pkg::REG_STRIDE_ROWS, sr);
    put_reg(mp2q_pkg::REG_STRIDE_COLS, sc);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    src_calm    = ($urandom_range(0, 3) == 0);
    sink_calm   = ($urandom_range(0, 3) == 0);
    shape_count++;
  endtask

  // whole maps with random content, now and then cut short or followed by stray words
  task automatic queue_maps(int unsigned nmaps);
    int unsigned h, w, chn, sr, sc, kr, kc, n, cut, m, i;
    shape_now(h, w, chn, sr, sc, kr, kc);
    n = h * w * chn;
    for (m = 0; m < nmaps; m++) begin
      cut = ($urandom_range(0, 5) == 0) ? $urandom_range(1, n) : n;
      for (i = 0; i < cut; i++)
        push_word(rand_sample(), (i == 0) ? (m == 0 || $urandom_range(0, 3) != 0)
                                          : ($urandom_range(0, 99) == 0));
    end
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 5)) push_word(rand_sample(), 1'($urandom_range(0, 1)));
  endtask

  initial begin : stimulus
    int unsigned h, w, chn, kr, kc, sr, sc, esr, esc, base;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    feed_ch.valid = 1'b0;
    feed_ch.data  = '0;
    pool_ch.ready = 1'b0;
    cfg_h  = 1;
    cfg_w  = 1;
    cfg_c  = 1;
    cfg_kr = 2;
    cfg_kc = 2;
    cfg_sr = 2;
    cfg_sc = 2;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset shape is smaller than one window: nothing comes out
    push_word(16'sh7fff, 1'b1);
    push_word(16'sh8000, 1'b0);

    // 2x2 map: all minimum, then a map restarted in the middle
    set_shape(2, 2, 1, 2, 2, 2, 2);
    repeat (4) push_word(16'sh8000, 1'b0);
    push_word(16'sh7fff, 1'b1);
    push_word(16'sd5, 1'b0);
    push_word(-16'sd1, 1'b1);
    push_word(16'sh7fff, 1'b0);
    push_word(16'sd0, 1'b0);
    push_word(-16'sd2, 1'b0);

    // height shrinks mid-map: the stale row is skipped and the position wraps to zero
    set_shape(4, 2, 1, 2, 2, 2, 2);
    push_word(16'sd100, 1'b1);
    push_word(-16'sd100, 1'b0);
    push_word(16'sd7, 1'b0);
    push_word(16'sd8, 1'b0);
    set_shape(2, 2, 1, 2, 2, 2, 2);
    push_word(16'sd1, 1'b0);
    push_word(16'sd2, 1'b0);
    push_word(16'sd3, 1'b0);
    push_word(-16'sd4, 1'b0);
    push_word(-16'sd5, 1'b0);
    push_word(-16'sd6, 1'b0);

    // register extremes: tallest map (first rows only), widest and deepest pixel rows,
    // largest steps
    set_shape(1023, 1, 1, 8, 1, 7, 1);
    push_word(rand_sample(), 1'b1);
    repeat (69) push_word(rand_sample(), 1'b0);
    set_shape(2, 100, 1, 15, 0, 2, 0);
    queue_maps(1);
    set_shape(0, 0, 127, 1, 1, 1, 1);
    queue_maps(1);
    set_shape(15, 15, 1, 15, 15, 15, 15);
    queue_maps(1);

    base = pushed;
    while (pushed - base < RANDOM_WORDS) begin
      do begin
        sr  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
        sc  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
        esr = (sr == 0) ? 1 : sr;
        esc = (sc == 0) ? 1 : sc;
        kr  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, esr);
        kc  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, esc);
        h   = esr * $urandom_range(0, 3) + $urandom_range(0, 2);
        w   = esc * $urandom_range(0, 3) + $urandom_range(0, 2);
        chn = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8) : $urandom_range(1, 3);
      end while (((h == 0) ? 1 : h) * ((w == 0) ? 1 : w) * ((chn == 0) ? 1 : chn) > 300);
      set_shape(h, w, chn, kr, kc, sr, sc);
      queue_maps($urandom_range(1, 3));
    end

    settle();
    $display("fed %0d samples through %0d register settings", taken, shape_count);
    $display("checked %0d pooled words, %0d mismatches", checked, fail_count);
    if (fail_count == 0)
      $display("max_pool_2d_q15_unit regression: pass");
    else
      $display("max_pool_2d_q15_unit regression: fail");
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("%0t: run timed out, %0d of %0d samples taken, %0d pooled words pending",
             $time, taken, pushed, pooled_q.size());
    $display("max_pool_2d_q15_unit regression: fail");
    $finish;
  end

endmodule

/* files.f */
rtl/mp2q_pkg.sv
rtl/mp2q_if.sv
rtl/mp2q_cfg.sv
rtl/mp2q_addr.sv
rtl/mp2q_ram.sv
rtl/max_pool_2d_q15_unit.sv
rtl/mp2q_checker.sv
sim/tb_max_pool_2d_q15_unit.sv
